// ===== hdl/chbd_pkg.sv =====
// Shared types, codes and helpers for the chunked body decoder.
package chbd_pkg;

    localparam int SIZE_W     = 32;
    localparam int DISC_W     = 32;
    localparam int WIDE_W     = (SIZE_W > DISC_W) ? SIZE_W : DISC_W;
    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [1:0] END_ZERO    = 2'd0;
    localparam logic [1:0] END_BADSIZE = 2'd1;
    localparam logic [1:0] END_BETWEEN = 2'd2;
    localparam logic [1:0] END_INSIDE  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic              kind;
        logic [7:0]        payload_byte;
        logic [1:0]        end_code;
        logic [DISC_W-1:0] discard_count;
        logic              run_last;
    } out_item_t;

    // One classified input byte: an optional payload byte, then an optional end item
    typedef struct packed {
        logic              has_byte;
        logic [7:0]        data_byte;
        logic              has_end;
        logic [1:0]        end_code;
        logic [DISC_W-1:0] discard_count;
    } action_t;

    // {valid, value} of an ASCII hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic [DISC_W-1:0] sat_discard(input logic [SIZE_W-1:0] v);
        logic [DISC_W-1:0] r;
        if (WIDE_W'(v) > WIDE_W'({DISC_W{1'b1}})) begin
            r = {DISC_W{1'b1}};
        end
        else begin
            r = DISC_W'(v);
        end
        return r;
    endfunction

endpackage

// ===== hdl/http_chunked_body_decoder.sv =====
// Top level of the HTTP chunked body decoder.
//
// Input channel: raw body bytes with a last-byte flag, one item per push while
// full is low. Result channel: payload bytes and end-of-body status items,
// read like a queue (empty, pop); the oldest result sits on result.
//
// The front end parses size lines, data and trailers and writes at most one
// action per byte into a four-entry queue. The back end turns each action into
// one or two results and holds the current one in an output register.
//
// A payload byte or end item is written into the queue when its byte is taken,
// then loaded into the output register, where it can be popped. Throughput: one
// byte per cycle while full is low; a byte that yields both a payload byte and
// an end item holds its action in the queue until both results have passed
// through the single output register. Size-line and trailer bytes yield no result.
//
// Reset clears the parser to the start of a size line and empties the queue
// and output register. When the receiver stops popping, the output register
// holds, the queue fills, and full rises to stall the sender; nothing is lost.
module http_chunked_body_decoder
    import chbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  in_item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic    accept;
    logic    act_valid;
    action_t act_in;
    action_t act_head;
    logic    act_pop;
    logic    act_empty;

    // take a byte only while the queue has room
    assign accept = push && !full;

    chbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_item   (in_item),
        .act_valid (act_valid),
        .act       (act_in)
    );

    chbd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (act_valid),
        .wr_data (act_in),
        .rd_en   (act_pop),
        .rd_data (act_head),
        .full    (full),
        .empty   (act_empty)
    );

    chbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .act_empty (act_empty),
        .act       (act_head),
        .act_pop   (act_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== hdl/chbd_front.sv =====
// Front end: parses body bytes and turns each into an action for the back end.
module chbd_front
    import chbd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t in_item,
    output logic     act_valid,
    output action_t  act
);

    localparam logic [1:0] MODE_SIZE  = 2'd0;
    localparam logic [1:0] MODE_DATA  = 2'd1;
    localparam logic [1:0] MODE_TRAIL = 2'd2;
    localparam logic [1:0] MODE_STOP  = 2'd3;

    logic [1:0]        mode_reg, mode_next;
    logic              saw_cr_reg, saw_cr_next;
    logic              open_reg, open_next;
    logic              saw_digit_reg, saw_digit_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SIZE_W-1:0] left_reg, left_next;
    logic [SIZE_W-1:0] count_reg, count_next;
    logic [1:0]        trail_reg, trail_next;
    logic [1:0]        stop_reg, stop_next;
    logic [4:0]        hv;
    logic              cut;

    always_comb
    begin
        mode_next      = mode_reg;
        saw_cr_next    = saw_cr_reg;
        open_next      = open_reg;
        saw_digit_next = saw_digit_reg;
        size_next      = size_reg;
        left_next      = left_reg;
        count_next     = count_reg;
        trail_next     = trail_reg;
        stop_next      = stop_reg;
        cut            = 1'b0;
        hv             = hex_value(in_item.data_byte);
        act            = '0;
        act.data_byte  = in_item.data_byte;

        case (mode_reg)
            MODE_SIZE:
            begin
                if (saw_cr_reg && in_item.data_byte == CHAR_LF) begin
                    if (!saw_digit_reg || size_reg == '0) begin
                        stop_next = saw_digit_reg ? END_ZERO : END_BADSIZE;
                        mode_next = MODE_STOP;
                    end
                    else begin
                        left_next  = size_reg;
                        count_next = '0;
                        mode_next  = MODE_DATA;
                    end
                end
                else begin
                    if (open_reg && hv[4]) begin
                        // saturate once a digit would push past the top nibble
                        if (size_reg[SIZE_W-1 -: 4] != 4'd0) begin
                            size_next = {SIZE_W{1'b1}};
                        end
                        else begin
                            size_next = {size_reg[SIZE_W-5:0], hv[3:0]};
                        end
                        saw_digit_next = 1'b1;
                    end
                    else begin
                        open_next = 1'b0;
                    end
                    saw_cr_next = (in_item.data_byte == CHAR_CR);
                end
            end
            MODE_DATA:
            begin
                act.has_byte = 1'b1;
                left_next    = left_reg - 1'b1;
                count_next   = count_reg + 1'b1;
                if (left_reg == SIZE_W'(1)) begin
                    trail_next = 2'd2;
                    mode_next  = MODE_TRAIL;
                end
                else begin
                    cut = 1'b1;
                end
            end
            MODE_TRAIL:
            begin
                trail_next = trail_reg - 1'b1;
                if (trail_reg == 2'd1) begin
                    mode_next      = MODE_SIZE;
                    saw_cr_next    = 1'b0;
                    open_next      = 1'b1;
                    saw_digit_next = 1'b0;
                    size_next      = '0;
                end
            end
            default:
            begin
                mode_next = MODE_STOP;
            end
        endcase

        if (in_item.is_last) begin
            act.has_end = 1'b1;
            if (mode_next == MODE_STOP) begin
                act.end_code = stop_next;
            end
            else if (cut) begin
                act.end_code      = END_INSIDE;
                act.discard_count = sat_discard(count_next);
            end
            else begin
                act.end_code = END_BETWEEN;
            end
            // back to the reset state for the next body
            mode_next      = MODE_SIZE;
            saw_cr_next    = 1'b0;
            open_next      = 1'b1;
            saw_digit_next = 1'b0;
            size_next      = '0;
            left_next      = '0;
            count_next     = '0;
            trail_next     = 2'd0;
            stop_next      = END_ZERO;
        end
    end

    assign act_valid = accept && (act.has_byte || act.has_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg      <= MODE_SIZE;
            saw_cr_reg    <= 1'b0;
            open_reg      <= 1'b1;
            saw_digit_reg <= 1'b0;
            size_reg      <= '0;
            left_reg      <= '0;
            count_reg     <= '0;
            trail_reg     <= 2'd0;
            stop_reg      <= END_ZERO;
        end
        else if (accept) begin
            mode_reg      <= mode_next;
            saw_cr_reg    <= saw_cr_next;
            open_reg      <= open_next;
            saw_digit_reg <= saw_digit_next;
            size_reg      <= size_next;
            left_reg      <= left_next;
            count_reg     <= count_next;
            trail_reg     <= trail_next;
            stop_reg      <= stop_next;
        end
    end

endmodule

// ===== hdl/chbd_fifo.sv =====
// Short action queue between the front and back ends.
module chbd_fifo
    import chbd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  action_t wr_data,
    input  logic    rd_en,
    output action_t rd_data,
    output logic    full,
    output logic    empty
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    action_t            mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               do_wr, do_rd;

    assign full    = (cnt_reg == CNT_W'(FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/chbd_back.sv =====
// Back end: expands each action into result items and holds them in the output register.
module chbd_back
    import chbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      act_empty,
    input  action_t   act,
    output logic      act_pop,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    out_item_t out_reg, out_next;
    logic      valid_reg, valid_next;
    logic      phase_reg, phase_next;
    logic      load;

    always_comb
    begin
        load       = !act_empty && (!valid_reg || pop);
        out_next   = out_reg;
        valid_next = valid_reg;
        phase_next = phase_reg;
        act_pop    = 1'b0;

        if (load) begin
            valid_next = 1'b1;
            out_next   = '0;
            if (act.has_byte && !phase_reg) begin
                out_next.kind         = KIND_DATA;
                out_next.payload_byte = act.data_byte;
                out_next.run_last     = !act.has_end;
                if (act.has_end) begin
                    // hold the action for its end item
                    phase_next = 1'b1;
                end
                else begin
                    act_pop = 1'b1;
                end
            end
            else begin
                out_next.kind          = KIND_END;
                out_next.end_code      = act.end_code;
                out_next.discard_count = act.discard_count;
                out_next.run_last      = 1'b1;
                phase_next             = 1'b0;
                act_pop                = 1'b1;
            end
        end
        else if (pop) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    assign empty  = !valid_reg;
    assign result = out_reg;

endmodule

// ===== tb/tb_http_chunked_body_decoder.sv =====
// Self-checking testbench for the HTTP chunked body decoder: byte stimulus, prediction, checks.
module tb_http_chunked_body_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    import chbd_pkg::*;

    // Run shape
    localparam int RANDOM_ITEMS = 550;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 8;
    localparam int STEADY_FROM  = 200;
    localparam int STEADY_TO    = 350;
    localparam int IDLE_PERCENT = 13;

    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    typedef enum logic [1:0] {
        SIZE_LINE,
        CHUNK_DATA,
        CHUNK_TRAILER,
        DECODE_STOPPED
    } parse_mode_t;

    // Ports
    logic      clk     = 1'b0;
    logic      rst_n   = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    in_item_t  in_item = '0;
    logic      full;
    logic      empty;
    out_item_t result;

    // Body bytes waiting for the driver, and results still owed by the block
    in_item_t  body_bytes[$];
    out_item_t decoded_queue[$];
    // Item counts at which the driver holds until every owed result has come
    int        drain_points[$];
    // Body under construction before it is handed to the driver
    logic [7:0] draft[$];

    // Decoder state as the checker sees it
    parse_mode_t       mode;
    logic              saw_cr;
    logic              digits_open;
    logic              saw_digit;
    logic [SIZE_W-1:0] chunk_size;
    logic [SIZE_W-1:0] bytes_left;
    logic [1:0]        trailer_left;
    logic [1:0]        stop_code;

    // Bookkeeping
    int   bytes_sent    = 0;
    int   cycle_count   = 0;
    int   error_count   = 0;
    int   bodies_built  = 0;
    int   payload_count = 0;
    int   end_seen[4]   = '{0, 0, 0, 0};
    logic in_taken      = 1'b0;
    logic steady_stretch;

    // A long stretch in the middle of the run with neither side idling
    assign steady_stretch = (bytes_sent >= STEADY_FROM) && (bytes_sent < STEADY_TO);

    always #2 clk = ~clk;

    http_chunked_body_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    // Return to the start of a size line with the digit field open
    function automatic void start_size_line();
        mode        = SIZE_LINE;
        saw_cr      = 1'b0;
        digits_open = 1'b1;
        saw_digit   = 1'b0;
        chunk_size  = '0;
    endfunction

    // Back to the reset state, ready for a fresh body
    function automatic void clear_decoder();
        start_size_line();
        bytes_left   = '0;
        trailer_left = 2'd0;
        stop_code    = END_ZERO;
    endfunction

    // Advance the decoder by one accepted body byte and queue the results it owes
    function automatic void decode_byte(input in_item_t it);
        out_item_t         r;
        logic [7:0]        c;
        logic [SIZE_W-1:0] dval;
        logic              is_hex;
        logic              cut;
        logic [SIZE_W-1:0] emitted;
        c       = it.data_byte;
        cut     = 1'b0;
        emitted = '0;
        is_hex  = 1'b1;
        dval    = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            dval = SIZE_W'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            dval = SIZE_W'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            dval = SIZE_W'(c - 8'h37);
        end
        else begin
            is_hex = 1'b0;
        end

        case (mode)
            SIZE_LINE: begin
                if (saw_cr && c == CHAR_LF) begin
                    // Line complete: a zero size or no digits at all stops the body
                    if (!saw_digit || chunk_size == '0) begin
                        stop_code = saw_digit ? END_ZERO : END_BADSIZE;
                        mode      = DECODE_STOPPED;
                    end
                    else begin
                        bytes_left = chunk_size;
                        mode       = CHUNK_DATA;
                    end
                end
                else begin
                    if (digits_open && is_hex) begin
                        // Saturate rather than wrap on an oversized length
                        if (chunk_size > (SIZE_MAX - dval) / 16) begin
                            chunk_size = SIZE_MAX;
                        end
                        else begin
                            chunk_size = chunk_size * 16 + dval;
                        end
                        saw_digit = 1'b1;
                    end
                    else begin
                        // First non-hex byte closes the digit field for good
                        digits_open = 1'b0;
                    end
                    saw_cr = (c == CHAR_CR);
                end
            end
            CHUNK_DATA: begin
                r              = '0;
                r.kind         = KIND_DATA;
                r.payload_byte = c;
                r.end_code     = END_ZERO;
                r.run_last     = !it.is_last;
                decoded_queue.push_back(r);
                payload_count++;
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == '0) begin
                    trailer_left = 2'd2;
                    mode         = CHUNK_TRAILER;
                end
                else begin
                    cut     = 1'b1;
                    emitted = chunk_size - bytes_left;
                end
            end
            CHUNK_TRAILER: begin
                // Skip both trailer bytes unchecked
                trailer_left = trailer_left - 1'b1;
                if (trailer_left == 2'd0) begin
                    start_size_line();
                end
            end
            default: ;
        endcase

        if (it.is_last) begin
            r          = '0;
            r.kind     = KIND_END;
            r.run_last = 1'b1;
            if (mode == DECODE_STOPPED) begin
                r.end_code = stop_code;
            end
            else if (cut) begin
                r.end_code      = END_INSIDE;
                r.discard_count = (SIZE_W > DISC_W && (emitted >> DISC_W) != 0) ?
                                  '1 : DISC_W'(emitted);
            end
            else begin
                r.end_code = END_BETWEEN;
            end
            decoded_queue.push_back(r);
            end_seen[r.end_code]++;
            clear_decoder();
        end
    endfunction

    // ------------------------------------------------------------------
    // Body construction
    // ------------------------------------------------------------------

    task automatic append_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            draft.push_back(s[i]);
        end
    endtask

    task automatic append_crlf();
        draft.push_back(CHAR_CR);
        draft.push_back(CHAR_LF);
    endtask

    // Random bytes; drop LF where a stray one could end a size line early
    task automatic append_random(input int n, input bit allow_lf);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(255));
            if (!allow_lf && b == CHAR_LF) begin
                b = "x";
            end
            draft.push_back(b);
        end
    endtask

    // Size line in hex with mixed case, optional leading zeros and extension
    task automatic append_size_line(input int unsigned size);
        string s;
        s = $sformatf("%0h", size);
        for (int i = 0; i < s.len(); i++) begin
            if (s[i] >= "a" && s[i] <= "f" && $urandom_range(1)) begin
                s[i] = s[i] - 8'h20;
            end
        end
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) begin
            draft.push_back("0");
        end
        append_str(s);
        if ($urandom_range(3) == 0) begin
            draft.push_back(";");
            append_random($urandom_range(0, 4), 1'b0);
        end
        append_crlf();
    endtask

    // Well-formed body: a few chunks, then the zero chunk and perhaps some junk
    task automatic append_well_formed();
        int unsigned size;
        repeat ($urandom_range(1, 4)) begin
            size = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 200);
            append_size_line(size);
            append_random(size, 1'b1);
            if ($urandom_range(5) == 0) begin
                append_random(2, 1'b1);
            end
            else begin
                append_crlf();
            end
        end
        append_size_line(0);
        if ($urandom_range(1)) begin
            append_crlf();
        end
        if ($urandom_range(4) == 0) begin
            append_random($urandom_range(1, 4), 1'b1);
        end
    endtask

    // Hand the draft to the driver, flagging byte last_at as final and dropping the rest
    task automatic commit_body(input int last_at);
        in_item_t it;
        for (int i = 0; i <= last_at; i++) begin
            it.data_byte = draft[i];
            it.is_last   = (i == last_at);
            body_bytes.push_back(it);
        end
        draft.delete();
        bodies_built++;
    endtask

    task automatic commit_whole();
        commit_body(draft.size() - 1);
    endtask

    // ------------------------------------------------------------------
    // Driver: present the next body byte at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk) begin : drive_inputs
        logic hold;
        hold = 1'b0;
        if (in_taken) begin
            body_bytes.delete(0);
        end
        // Hold at a drain point until nothing more is owed
        if (drain_points.size() != 0 && bytes_sent == drain_points[0]) begin
            if (decoded_queue.size() == 0) begin
                drain_points.delete(0);
            end
            hold = 1'b1;
        end
        if (!steady_stretch && $urandom_range(99) < IDLE_PERCENT) begin
            hold = 1'b1;
        end
        if (rst_n && !hold && body_bytes.size() != 0) begin
            push    <= 1'b1;
            in_item <= body_bytes[0];
        end
        else begin
            push <= 1'b0;
        end
    end

    // Result side: stall the block at random outside the steady stretch
    always @(negedge clk) begin
        pop <= rst_n && (steady_stretch || $urandom_range(99) >= IDLE_PERCENT);
    end

    task automatic report_field(input string name, input logic [DISC_W-1:0] want,
                                input logic [DISC_W-1:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted byte, check each accepted result
    // ------------------------------------------------------------------
    always @(posedge clk) begin : check_results
        out_item_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run timed out with %0d results owed", $time, decoded_queue.size());
            $display("TB_ERROR");
            $finish;
        end
        else begin
            in_taken <= push && !full;
            if (push && !full) begin
                decode_byte(in_item);
                bytes_sent <= bytes_sent + 1;
            end
            if (pop && !empty) begin
                if (decoded_queue.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, got %p", $time, result);
                end
                else begin
                    want = decoded_queue.pop_front();
                    report_field("kind", DISC_W'(want.kind), DISC_W'(result.kind));
                    report_field("payload_byte", DISC_W'(want.payload_byte),
                                 DISC_W'(result.payload_byte));
                    report_field("end_code", DISC_W'(want.end_code), DISC_W'(result.end_code));
                    report_field("discard_count", want.discard_count, result.discard_count);
                    report_field("run_last", DISC_W'(want.run_last), DISC_W'(result.run_last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int    random_start;
        int    r;
        bit    mid_drain_set;
        string hex_chars;
        clear_decoder();
        mid_drain_set = 1'b0;
        hex_chars     = "0123456789abcdefABCDEF";

        // Directed bodies
        // bare CR LF: no digits, malformed size line
        append_crlf();
        commit_whole();
        // zero chunk, then an all-ones byte that must be ignored
        append_str("0");
        append_crlf();
        draft.push_back(8'hFF);
        commit_whole();
        // body ends on the LF of a nonzero size line, chunk never started
        append_str("2");
        append_crlf();
        commit_whole();
        // CR, CR, LF still ends the line; body ends inside the trailer
        append_str("1");
        draft.push_back(CHAR_CR);
        append_crlf();
        draft.push_back(8'h00);
        draft.push_back(CHAR_CR);
        commit_whole();
        // last byte completes the chunk
        append_str("1");
        append_crlf();
        append_str("k");
        commit_whole();
        // oversized length saturates; body cut just inside the data
        append_str("FFFFFFFFF");
        append_crlf();
        draft.push_back(8'h80);
        commit_whole();

        // Let everything directed drain before the random traffic starts
        random_start = body_bytes.size();
        drain_points.push_back(random_start);

        while (body_bytes.size() - random_start < RANDOM_ITEMS) begin
            if (!mid_drain_set && body_bytes.size() - random_start >= 400) begin
                drain_points.push_back(body_bytes.size());
                mid_drain_set = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 60) begin
                append_well_formed();
                commit_whole();
            end
            else if (r < 80) begin
                // truncate a well-formed body anywhere
                append_well_formed();
                commit_body($urandom_range(draft.size() - 1));
            end
            else if (r < 88) begin
                // saturating size line, then a few data bytes and a cut
                append_str("1");
                repeat ($urandom_range(8, 11)) begin
                    draft.push_back(hex_chars[$urandom_range(21)]);
                end
                append_crlf();
                append_random($urandom_range(1, 6), 1'b1);
                commit_whole();
            end
            else if (r < 94) begin
                // size line with no leading digit
                append_str($urandom_range(1) ? ";x" : "g1");
                append_crlf();
                append_random($urandom_range(0, 3), 1'b1);
                commit_whole();
            end
            else begin
                append_random($urandom_range(1, 6), 1'b1);
                commit_whole();
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (body_bytes.size() != 0 || decoded_queue.size() != 0) begin
            @(negedge clk);
        end
        // Allow the pipeline to settle so any stray result is caught
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d bodies, %0d bytes; checked %0d payload bytes.",
                 bodies_built, bytes_sent, payload_count);
        $display("End items: zero chunk %0d, bad size %0d, between chunks %0d, inside data %0d.",
                 end_seen[END_ZERO], end_seen[END_BADSIZE], end_seen[END_BETWEEN],
                 end_seen[END_INSIDE]);
        if (error_count == 0) begin
            $display("TB_OK");
        end
        else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
